>>> rtl/core/rpbp_pkg.sv
package rpbp_pkg;

   // fixed point formats
   localparam int NORM_FRAC   = 12;
   localparam int NORM_ONE    = 4096;
   localparam int X_W         = 16;
   localparam int IN_W        = 16;
   localparam int INV_W       = 24;
   localparam int COEF_W      = 32;
   localparam int ACC_W       = 64;
   localparam int PWM_W       = 16;

   // coefficient table
   localparam int TABLE_DEPTH = 21;
   localparam int SLOT_W      = 5;

   // configuration port
   localparam int IDX_W       = 3;
   localparam int CSR_W       = 24;

   typedef enum logic {
      OP_EVAL = 1'b0,
      OP_LOAD = 1'b1
   } opcode_type;

   typedef enum logic [IDX_W-1:0] {
      REG_PWM_LOW   = 3'd0,
      REG_PWM_HIGH  = 3'd1,
      REG_SPEED_AVG = 3'd2,
      REG_SPEED_INV = 3'd3,
      REG_VOLT_AVG  = 3'd4,
      REG_VOLT_INV  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      LIM_OK   = 2'd0,
      LIM_LOW  = 2'd1,
      LIM_HIGH = 2'd2
   } limit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NORM,
      ST_EVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [PWM_W-1:0] pwm_low;
      logic [PWM_W-1:0] pwm_high;
      logic [IN_W-1:0]  speed_avg;
      logic [INV_W-1:0] speed_inv;
      logic [IN_W-1:0]  volt_avg;
      logic [INV_W-1:0] volt_inv;
   } csr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } coef_rd_type;

endpackage

>>> rtl/core/rpbp_ram.sv
module rpbp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 21
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rpbp_norm.sv
module rpbp_norm (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [rpbp_pkg::IN_W-1:0]              speed,
   input  logic [rpbp_pkg::IN_W-1:0]              battery,
   input  rpbp_pkg::csr_type                      csr,
   output logic                                   done,
   output logic signed [rpbp_pkg::X_W-1:0]        x,
   output logic signed [rpbp_pkg::X_W-1:0]        y
);

   import rpbp_pkg::*;

   localparam int D_W = IN_W + 1;
   localparam int P_W = D_W + INV_W + 1;

   logic                  vld_ff, vld_in;
   logic                  done_ff, done_in;
   logic signed [D_W-1:0] ds, dv;
   logic signed [P_W-1:0] ps_ff, ps_in, pv_ff, pv_in;
   logic signed [X_W-1:0] x_ff, x_in, y_ff, y_in;

   // floor shift by the norm fraction, then saturate to q4.12
   function automatic logic [X_W-1:0] sat_x(input logic [P_W-1:0] p);
      logic [P_W-NORM_FRAC-X_W:0] hi;
      hi = p[P_W-1:NORM_FRAC+X_W-1];
      if ((&hi) || !(|hi)) begin
         sat_x = p[NORM_FRAC+X_W-1:NORM_FRAC];
      end else if (p[P_W-1]) begin
         sat_x = {1'b1, {(X_W-1){1'b0}}};
      end else begin
         sat_x = {1'b0, {(X_W-1){1'b1}}};
      end
   endfunction

   always_comb begin
      ds      = $signed({1'b0, speed}) - $signed({1'b0, csr.speed_avg});
      dv      = $signed({1'b0, battery}) - $signed({1'b0, csr.volt_avg});
      ps_in   = ds * $signed({1'b0, csr.speed_inv});
      pv_in   = dv * $signed({1'b0, csr.volt_inv});
      vld_in  = start;
      done_in = vld_ff;
      x_in    = vld_ff ? $signed(sat_x(ps_ff)) : x_ff;
      y_in    = vld_ff ? $signed(sat_x(pv_ff)) : y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         done_ff <= done_in;
      end
      if (start) begin
         ps_ff <= ps_in;
         pv_ff <= pv_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign done = done_ff;
   assign x    = x_ff;
   assign y    = y_ff;

endmodule

>>> rtl/core/rpbp_eval.sv
module rpbp_eval #(
   parameter int POLY_DEGREE = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [rpbp_pkg::X_W-1:0]        x,
   input  logic signed [rpbp_pkg::X_W-1:0]        y,
   output rpbp_pkg::coef_rd_type                  coef_rd,
   input  logic signed [rpbp_pkg::COEF_W-1:0]     coef_q,
   output logic                                   done,
   output logic signed [rpbp_pkg::ACC_W-1:0]      acc
);

   import rpbp_pkg::*;

   localparam int TERMS  = (POLY_DEGREE + 1) * (POLY_DEGREE + 2) / 2;
   localparam int MON_W  = 3 * POLY_DEGREE + 14;
   localparam int MON_AW = $clog2(TERMS);
   localparam int DEG_W  = $clog2(POLY_DEGREE + 1);
   localparam int MP_W   = MON_W + X_W;
   localparam int CP_W   = COEF_W + MON_W;

   logic                     run_ff, run_in;
   logic                     phase_ff, phase_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [DEG_W-1:0]         deg_ff, deg_in, pos_ff, pos_in;
   logic                     last_term;
   logic [SLOT_W-1:0]        parent;
   logic signed [X_W-1:0]    mul_op;
   logic signed [MON_W-1:0]  mon_q, mon_new;
   logic signed [MP_W-1:0]   mon_prod;
   logic                     mon_wr;
   logic                     term_vld_ff, term_vld_in, term_last_ff, term_last_in;
   logic signed [MON_W-1:0]  mon_ff;
   logic signed [COEF_W-1:0] coef_ff;
   logic                     prod_vld_ff, prod_vld_in, prod_last_ff, prod_last_in;
   logic signed [CP_W-1:0]   prod_full;
   logic signed [ACC_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     done_ff, done_in;

   // parent monomial sits one degree down: same position for pure x powers, one back otherwise
   always_comb begin
      last_term = (slot_ff == SLOT_W'(TERMS - 1));
      if (pos_ff == '0) begin
         parent = slot_ff - SLOT_W'(deg_ff);
         mul_op = x;
      end else begin
         parent = slot_ff - SLOT_W'(deg_ff) - SLOT_W'(1);
         mul_op = y;
      end
      coef_rd.en   = run_ff && !phase_ff;
      coef_rd.addr = slot_ff;
      mon_wr       = run_ff && phase_ff;
      mon_prod     = mon_q * mul_op;
      mon_new      = (slot_ff == '0) ? MON_W'(NORM_ONE) : mon_prod[MON_W+NORM_FRAC-1:NORM_FRAC];
   end

   rpbp_ram #(
      .WIDTH (MON_W),
      .DEPTH (TERMS)
   ) u_mon_ram (
      .clock   (clock),
      .wr_en   (mon_wr),
      .wr_addr (slot_ff[MON_AW-1:0]),
      .wr_data (mon_new),
      .rd_en   (coef_rd.en),
      .rd_addr (parent[MON_AW-1:0]),
      .rd_data (mon_q)
   );

   // term sequencer, a read phase then a write phase per term
   always_comb begin
      run_in   = run_ff;
      phase_in = phase_ff;
      slot_in  = slot_ff;
      deg_in   = deg_ff;
      pos_in   = pos_ff;
      if (start) begin
         run_in   = 1'b1;
         phase_in = 1'b0;
         slot_in  = '0;
         deg_in   = '0;
         pos_in   = '0;
      end else if (run_ff) begin
         phase_in = !phase_ff;
         if (phase_ff) begin
            slot_in = slot_ff + SLOT_W'(1);
            if (pos_ff == deg_ff) begin
               deg_in = deg_ff + DEG_W'(1);
               pos_in = '0;
            end else begin
               pos_in = pos_ff + DEG_W'(1);
            end
            if (last_term) begin
               run_in = 1'b0;
            end
         end
      end
   end

   // multiply and accumulate pipeline
   always_comb begin
      term_vld_in  = mon_wr;
      term_last_in = last_term;
      prod_full    = coef_ff * mon_ff;
      prod_in      = {{(ACC_W-CP_W){prod_full[CP_W-1]}}, prod_full};
      prod_vld_in  = term_vld_ff;
      prod_last_in = term_last_ff;
      if (start) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
      done_in = prod_vld_ff && prod_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         phase_ff    <= 1'b0;
         slot_ff     <= '0;
         deg_ff      <= '0;
         pos_ff      <= '0;
         term_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         run_ff      <= run_in;
         phase_ff    <= phase_in;
         slot_ff     <= slot_in;
         deg_ff      <= deg_in;
         pos_ff      <= pos_in;
         term_vld_ff <= term_vld_in;
         prod_vld_ff <= prod_vld_in;
         done_ff     <= done_in;
      end
      if (mon_wr) begin
         mon_ff  <= mon_new;
         coef_ff <= coef_q;
      end
      term_last_ff <= term_last_in;
      prod_last_ff <= prod_last_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

>>> rtl/core/rpbp_limit.sv
module rpbp_limit #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic signed [rpbp_pkg::ACC_W-1:0] acc,
   input  logic [rpbp_pkg::PWM_W-1:0]        pwm_low,
   input  logic [rpbp_pkg::PWM_W-1:0]        pwm_high,
   output logic [rpbp_pkg::PWM_W-1:0]        cmd,
   output rpbp_pkg::limit_type               status
);

   import rpbp_pkg::*;

   localparam int SH  = COEF_FRAC_BITS + NORM_FRAC;
   localparam int T_W = ACC_W - SH;

   logic [ACC_W-1:0] sum;
   logic [T_W-1:0]   t;

   always_comb begin
      sum = acc + (ACC_W'(1) << (SH - 1));
      t   = acc[ACC_W-1] ? '0 : sum[ACC_W-1:SH];
      // high limit wins, also when the limits cross
      if (t > T_W'(pwm_high)) begin
         cmd    = pwm_high;
         status = LIM_HIGH;
      end else if (t < T_W'(pwm_low)) begin
         cmd    = pwm_low;
         status = LIM_LOW;
      end else begin
         cmd    = t[PWM_W-1:0];
         status = LIM_OK;
      end
   end

endmodule

>>> rtl/core/rpm_to_pwm_bivariate_poly_unit.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tuser opcode; tdata speed, battery, slot, coefficient
// rsp     | out | rsp_tvalid/rsp_tready | tdata pwm command, limit status
// csr     | in  | csr_valid/csr_ready   | csr_index register, csr_data value
//
// a load item writes the coefficient table as it is taken; an evaluate item goes through
// normalization and then, for each term, the monomial ram read, multiply and write back
// before its result. one item is worked on at a time; the next is taken while a result waits.
// reset is synchronous: limits and spreads return to defaults, the coefficient valid bits
// clear so every slot reads as zero. a stalled result holds the output register and keeps
// a finished evaluation waiting in its last state.
module rpm_to_pwm_bivariate_poly_unit #(
   parameter int POLY_DEGREE    = 5,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // speed_rpm[15:0], battery_mv[31:16], coef_slot[36:32],
                                   // coef_value[68:37], zero fill
   input  logic [0:0]  req_tuser,  // opcode[0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // pwm_command[15:0], limit_status[17:16], zero fill
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   import rpbp_pkg::*;

   state_type               state_ff, state_in;
   csr_type                 csr_ff, csr_in;

   logic                    req_acc;
   opcode_type              req_op;
   logic [IN_W-1:0]         req_speed, req_batt;
   logic [SLOT_W-1:0]       req_slot;
   logic [COEF_W-1:0]       req_coef;

   logic                    coef_wr;
   logic [TABLE_DEPTH-1:0]  coef_vld_ff, coef_vld_in;
   logic                    coef_rd_vld_ff;
   logic [COEF_W-1:0]       coef_ram_q;
   logic signed [COEF_W-1:0] coef_q;
   coef_rd_type             coef_rd;

   logic                    norm_start, norm_done;
   logic signed [X_W-1:0]   x, y;
   logic                    eval_start, eval_done;
   logic signed [ACC_W-1:0] acc;

   logic [PWM_W-1:0]        lim_cmd;
   limit_type               lim_status;
   logic                    rsp_load;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [PWM_W-1:0]        rsp_cmd_ff;
   limit_type               rsp_stat_ff;

   // request fields
   assign req_op    = opcode_type'(req_tuser[0]);
   assign req_speed = req_tdata[15:0];
   assign req_batt  = req_tdata[31:16];
   assign req_slot  = req_tdata[36:32];
   assign req_coef  = req_tdata[68:37];
   assign req_acc   = req_tvalid && req_tready;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PWM_LOW:   csr_in.pwm_low   = csr_data[PWM_W-1:0];
            REG_PWM_HIGH:  csr_in.pwm_high  = csr_data[PWM_W-1:0];
            REG_SPEED_AVG: csr_in.speed_avg = csr_data[IN_W-1:0];
            REG_SPEED_INV: csr_in.speed_inv = csr_data[INV_W-1:0];
            REG_VOLT_AVG:  csr_in.volt_avg  = csr_data[IN_W-1:0];
            REG_VOLT_INV:  csr_in.volt_inv  = csr_data[INV_W-1:0];
            default: ;     // index beyond the register list is dropped
         endcase
      end
   end

   // coefficient table: one ram, valid bits give the zero reset
   assign coef_wr = req_acc && (req_op == OP_LOAD) && (req_slot < SLOT_W'(TABLE_DEPTH));

   always_comb begin
      coef_vld_in = coef_vld_ff;
      if (coef_wr) begin
         coef_vld_in = coef_vld_ff | (TABLE_DEPTH'(1) << req_slot);
      end
   end

   rpbp_ram #(
      .WIDTH (COEF_W),
      .DEPTH (TABLE_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (req_slot),
      .wr_data (req_coef),
      .rd_en   (coef_rd.en),
      .rd_addr (coef_rd.addr),
      .rd_data (coef_ram_q)
   );

   // never written slots read as zero
   assign coef_q = coef_rd_vld_ff ? $signed(coef_ram_q) : '0;

   rpbp_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .start   (norm_start),
      .speed   (req_speed),
      .battery (req_batt),
      .csr     (csr_ff),
      .done    (norm_done),
      .x       (x),
      .y       (y)
   );

   rpbp_eval #(
      .POLY_DEGREE (POLY_DEGREE)
   ) u_eval (
      .clock   (clock),
      .reset   (reset),
      .start   (eval_start),
      .x       (x),
      .y       (y),
      .coef_rd (coef_rd),
      .coef_q  (coef_q),
      .done    (eval_done),
      .acc     (acc)
   );

   rpbp_limit #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_limit (
      .acc      (acc),
      .pwm_low  (csr_ff.pwm_low),
      .pwm_high (csr_ff.pwm_high),
      .cmd      (lim_cmd),
      .status   (lim_status)
   );

   // control: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_op == OP_EVAL)) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (norm_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_vld_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control: outputs
   always_comb begin
      req_tready = 1'b0;
      norm_start = 1'b0;
      eval_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            norm_start = req_tvalid && (req_op == OP_EVAL);
         end
         ST_NORM: eval_start = norm_done;
         ST_EVAL: ;
         ST_DONE: rsp_load = !rsp_vld_ff || rsp_tready;
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         csr_ff.pwm_low     <= PWM_W'(1000);
         csr_ff.pwm_high    <= PWM_W'(2000);
         csr_ff.speed_avg   <= '0;
         csr_ff.speed_inv   <= INV_W'(4096);
         csr_ff.volt_avg    <= '0;
         csr_ff.volt_inv    <= INV_W'(4096);
         coef_vld_ff        <= '0;
         rsp_vld_ff         <= 1'b0;
      end else begin
         state_ff    <= state_in;
         csr_ff      <= csr_in;
         coef_vld_ff <= coef_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      if (coef_rd.en) begin
         coef_rd_vld_ff <= coef_vld_ff[coef_rd.addr];
      end
      if (rsp_load) begin
         rsp_cmd_ff  <= lim_cmd;
         rsp_stat_ff <= lim_status;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'b0, rsp_stat_ff, rsp_cmd_ff};

   // checks
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result appeared outside the finishing state");

   a_eval_done_state: assert property (@(posedge clock) disable iff (reset)
      eval_done |-> state_ff == ST_EVAL)
      else $error("evaluation finished while not evaluating");

   a_norm_done_state: assert property (@(posedge clock) disable iff (reset)
      norm_done |-> state_ff == ST_NORM)
      else $error("normalization finished while not normalizing");

   a_coef_addr: assert property (@(posedge clock) disable iff (reset)
      coef_rd.en |-> (coef_rd.addr < SLOT_W'(TABLE_DEPTH)) && (state_ff == ST_EVAL))
      else $error("coefficient read out of range or out of sequence");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import rpbp_pkg::*;

   localparam int POLY_DEG     = 5;
   localparam int COEF_FRAC    = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 64;      // comfortably longer than an evaluate item takes
   localparam int PHASES       = 6;
   localparam int RANDOM_ITEMS = 500;
   localparam int NUM_REGS     = int'(REG_VOLT_INV) + 1;
   localparam int SLOT_MAX     = 2**SLOT_W - 1;

   // one request item, unpacked
   typedef struct {
      opcode_type        op;
      logic [IN_W-1:0]   speed;
      logic [IN_W-1:0]   batt;
      logic [SLOT_W-1:0] slot;
      logic [COEF_W-1:0] coef;
   } req_item_type;

   // one expected result item
   typedef struct {
      logic [PWM_W-1:0] pwm;
      limit_type        status;
   } pwm_result_type;

   // predicts pwm commands from accepted items and checks them against the output
   class pwm_scoreboard;
      csr_type        regs;
      int             coef_tab [TABLE_DEPTH];
      pwm_result_type pwm_q [$];
      int             mismatches;

      function new();
         regs.pwm_low   = 16'd1000;
         regs.pwm_high  = 16'd2000;
         regs.speed_avg = '0;
         regs.speed_inv = 24'd4096;
         regs.volt_avg  = '0;
         regs.volt_inv  = 24'd4096;
         foreach (coef_tab[i]) coef_tab[i] = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            REG_PWM_LOW:   regs.pwm_low   = data[PWM_W-1:0];
            REG_PWM_HIGH:  regs.pwm_high  = data[PWM_W-1:0];
            REG_SPEED_AVG: regs.speed_avg = data[IN_W-1:0];
            REG_SPEED_INV: regs.speed_inv = data;
            REG_VOLT_AVG:  regs.volt_avg  = data[IN_W-1:0];
            REG_VOLT_INV:  regs.volt_inv  = data;
            default: ;
         endcase
      endfunction

      // (value - avg) * inv in q4.12, floored and saturated to 16 bits
      function longint norm_q412(logic [IN_W-1:0] value, logic [IN_W-1:0] avg,
                                 logic [INV_W-1:0] inv);
         longint d, q;
         d = longint'(value) - longint'(avg);
         q = (d * longint'(inv)) >>> NORM_FRAC;
         if (q > 32767) q = 32767;
         else if (q < -32768) q = -32768;
         return q;
      endfunction

      function pwm_result_type predict_pwm(logic [IN_W-1:0] speed, logic [IN_W-1:0] batt);
         longint x, y, mono, acc, rounded;
         int slot;
         pwm_result_type r;
         x = norm_q412(speed, regs.speed_avg, regs.speed_inv);
         y = norm_q412(batt, regs.volt_avg, regs.volt_inv);
         acc = 0;
         slot = 0;
         for (int deg = 0; deg <= POLY_DEG; deg++) begin
            for (int px = deg; px >= 0; px--) begin
               mono = longint'(NORM_ONE);
               for (int k = 0; k < px; k++) mono = (mono * x) >>> NORM_FRAC;
               for (int k = 0; k < deg - px; k++) mono = (mono * y) >>> NORM_FRAC;
               acc += longint'(coef_tab[slot]) * mono;
               slot++;
            end
         end
         if (acc < 0) begin
            rounded = 0;
         end else begin
            rounded = (acc + (longint'(1) <<< (COEF_FRAC + NORM_FRAC - 1)))
                      >>> (COEF_FRAC + NORM_FRAC);
         end
         if (rounded > longint'(regs.pwm_high)) begin
            r.pwm    = regs.pwm_high;
            r.status = LIM_HIGH;
         end else if (rounded < longint'(regs.pwm_low)) begin
            r.pwm    = regs.pwm_low;
            r.status = LIM_LOW;
         end else begin
            r.pwm    = rounded[PWM_W-1:0];
            r.status = LIM_OK;
         end
         return r;
      endfunction

      function void note_item(req_item_type it);
         if (it.op == OP_LOAD) begin
            if (it.slot < TABLE_DEPTH) coef_tab[it.slot] = it.coef;
         end else begin
            pwm_q.push_back(predict_pwm(it.speed, it.batt));
         end
      endfunction

      function void check_result(logic [23:0] data);
         pwm_result_type want;
         if (pwm_q.size() == 0) begin
            $error("unexpected result item: pwm_command %0d", data[PWM_W-1:0]);
            mismatches++;
            return;
         end
         want = pwm_q.pop_front();
         if (data[PWM_W-1:0] !== want.pwm) begin
            $error("pwm_command: expected %0d, got %0d", want.pwm, data[PWM_W-1:0]);
            mismatches++;
         end
         if (data[PWM_W+1:PWM_W] !== want.status) begin
            $error("limit_status: expected %0d, got %0d", want.status, data[PWM_W+1:PWM_W]);
            mismatches++;
         end
      endfunction

      function int pending();
         return pwm_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   pwm_scoreboard sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count = 0;

   rpm_to_pwm_bivariate_poly_unit #(
      .POLY_DEGREE    (POLY_DEG),
      .COEF_FRAC_BITS (COEF_FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // every accepted result item is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // idle mix: receiver idles more, then the two swapped, then none
   function automatic void set_idle_mode(int mode);
      case (mode)
         0: begin send_idle_pct = 31; recv_idle_pct = 47; end
         1: begin send_idle_pct = 47; recv_idle_pct = 31; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
   endfunction

   // drive one item from a falling edge, hold until accepted, return on a falling edge
   // with valid still high so back-to-back items never toggle it
   task automatic send_item(req_item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, it.coef, it.slot, it.batt, it.speed};
      req_tuser  <= it.op;
      do @(posedge clock); while (!req_tready);
      sb.note_item(it);
      @(negedge clock);
   endtask

   task automatic load_coef(logic [SLOT_W-1:0] slot, logic [COEF_W-1:0] value);
      req_item_type it;
      it.op    = OP_LOAD;
      it.speed = IN_W'($urandom_range(0, 65535));
      it.batt  = IN_W'($urandom_range(0, 65535));
      it.slot  = slot;
      it.coef  = value;
      send_item(it);
   endtask

   task automatic eval_point(logic [IN_W-1:0] speed, logic [IN_W-1:0] batt);
      req_item_type it;
      it.op    = OP_EVAL;
      it.speed = speed;
      it.batt  = batt;
      it.slot  = SLOT_W'($urandom_range(0, SLOT_MAX));
      it.coef  = $urandom;
      send_item(it);
   endtask

   // register write, valid left high for the next write
   task automatic csr_write(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   // stop sending and wait for every pending result, then let any load finish
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // register settings per phase, extremes and crossed limits included
   task automatic program_phase(int p);
      logic [CSR_W-1:0] cfg [NUM_REGS];
      cfg[REG_PWM_LOW]   = CSR_W'($urandom_range(500, 1500));
      cfg[REG_PWM_HIGH]  = CSR_W'($urandom_range(1500, 3000));
      cfg[REG_SPEED_AVG] = CSR_W'($urandom_range(0, 65535));
      cfg[REG_SPEED_INV] = CSR_W'($urandom_range(256, 16384));
      cfg[REG_VOLT_AVG]  = CSR_W'($urandom_range(0, 65535));
      cfg[REG_VOLT_INV]  = CSR_W'($urandom_range(256, 65536));
      case (p)
         1: begin
            // widest limits, extreme normalization
            cfg[REG_PWM_LOW]   = 0;
            cfg[REG_PWM_HIGH]  = 65535;
            cfg[REG_SPEED_AVG] = 65535;
            cfg[REG_SPEED_INV] = 24'hFFFFFF;
            cfg[REG_VOLT_AVG]  = 0;
            cfg[REG_VOLT_INV]  = 0;
         end
         2: begin
            // crossed limits
            cfg[REG_PWM_LOW]  = 3000;
            cfg[REG_PWM_HIGH] = 1200;
         end
         4: begin
            // fully crossed limits, other extremes swapped
            cfg[REG_PWM_LOW]   = 65535;
            cfg[REG_PWM_HIGH]  = 0;
            cfg[REG_SPEED_AVG] = 0;
            cfg[REG_SPEED_INV] = 0;
            cfg[REG_VOLT_AVG]  = 65535;
            cfg[REG_VOLT_INV]  = 24'hFFFFFF;
         end
         5: begin
            // raw 24 bit data everywhere, upper bits of 16 bit registers dropped
            foreach (cfg[i]) cfg[i] = CSR_W'($urandom_range(0, 24'hFFFFFF));
         end
         default: ;
      endcase
      foreach (cfg[i]) csr_write(IDX_W'(i), cfg[i]);
      // indexes past the last register are ignored
      for (int i = NUM_REGS; i < 2**IDX_W; i++) begin
         csr_write(IDX_W'(i), CSR_W'($urandom_range(0, 24'hFFFFFF)));
      end
      csr_valid <= 1'b0;
   endtask

   // coefficients scaled so many results land inside the pwm range
   function automatic logic [COEF_W-1:0] shaped_coef(logic [SLOT_W-1:0] slot);
      int v;
      v = $urandom;
      if ($urandom_range(0, 9) == 0) return v;
      if (slot == 0) return {16'($urandom_range(0, 4000)), v[15:0]};
      return v >>> $urandom_range(8, 31);
   endfunction

   // half anywhere, half near the configured mean
   function automatic logic [IN_W-1:0] pick_input(logic [IN_W-1:0] avg);
      int v;
      if ($urandom_range(0, 1)) return IN_W'($urandom_range(0, 65535));
      v = int'(avg) + int'($urandom_range(0, 8000)) - 4000;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[IN_W-1:0];
   endfunction

   task automatic random_item(output bit counted);
      req_item_type it;
      it.op    = ($urandom_range(0, 99) < 25) ? OP_LOAD : OP_EVAL;
      it.speed = pick_input(sb.regs.speed_avg);
      it.batt  = pick_input(sb.regs.volt_avg);
      it.slot  = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(TABLE_DEPTH, SLOT_MAX))
                                             : SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.coef  = shaped_coef(it.slot);
      send_item(it);
      counted = !(it.op == OP_LOAD && it.slot >= TABLE_DEPTH);
   endtask

   initial begin
      int  n;
      bit  counted;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      set_idle_mode(0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset register values
      eval_point(0, 0);                       // empty table clamps low
      load_coef(0, 1500 << 16);
      eval_point(0, 0);                       // constant term only
      load_coef(1, 1 << 16);
      eval_point(2048, 0);                    // exactly one half rounds up
      eval_point(2047, 0);                    // just under one half
      eval_point(65535, 0);                   // x saturates high
      load_coef(20, 32'h7FFFFFFF);
      eval_point(0, 65535);                   // large y^5 term clamps high
      load_coef(20, 32'h80000000);
      eval_point(65535, 65535);               // negative sum gives zero
      load_coef(21, 32'hFFFFFFFF);            // slots past the table are ignored
      load_coef(SLOT_W'(SLOT_MAX), 32'h7FFFFFFF);
      eval_point(0, 0);

      // full 16 bit range: results past 65535 saturate instead of wrapping
      drain();
      csr_write(REG_PWM_LOW, 0);
      csr_write(REG_PWM_HIGH, 65535);
      csr_valid <= 1'b0;
      load_coef(20, 32'h7FFFFFFF);
      eval_point(0, 65535);
      load_coef(0, 0);
      load_coef(1, 0);
      load_coef(20, 0);
      eval_point(0, 0);                       // zero result at a zero lower limit

      // random phases: refill the whole table, then mixed loads and evaluates
      for (int p = 0; p < PHASES; p++) begin
         drain();
         program_phase(p);
         set_idle_mode(p % 3);
         for (int s = 0; s < TABLE_DEPTH; s++) load_coef(SLOT_W'(s), shaped_coef(SLOT_W'(s)));
         n = TABLE_DEPTH;
         while (n < RANDOM_ITEMS / PHASES) begin
            random_item(counted);
            if (counted) n++;
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/rpbp_pkg.sv
rtl/core/rpbp_ram.sv
rtl/core/rpbp_norm.sv
rtl/core/rpbp_eval.sv
rtl/core/rpbp_limit.sv
rtl/core/rpm_to_pwm_bivariate_poly_unit.sv
dv/tb.sv
